/* hdl/bqd_pkg.sv */
package bqd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int COEF_WIDTH = 18;
	localparam int COEF_FRAC = COEF_WIDTH - 4;

	localparam int OP_WIDTH = (SAMPLE_WIDTH > COEF_WIDTH) ? SAMPLE_WIDTH : COEF_WIDTH;
	localparam int CNT_WIDTH = $clog2(OP_WIDTH);
	// rounded product: full product shifted right by the fraction bits
	localparam int RND_WIDTH = 2 * OP_WIDTH + 1 - COEF_FRAC;
	// five rounded terms
	localparam int ACC_WIDTH = RND_WIDTH + 3;

	localparam int CFG_IDX_WIDTH = 3;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0] coef_t;
	typedef logic signed [OP_WIDTH-1:0] op_t;
	typedef logic signed [RND_WIDTH-1:0] rnd_t;
	typedef logic signed [ACC_WIDTH-1:0] acc_t;
	typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_GAIN_A0 = CFG_IDX_WIDTH'(0);
	localparam cfg_idx_t REG_FF_RATIO_ONE = CFG_IDX_WIDTH'(1);
	localparam cfg_idx_t REG_FF_RATIO_TWO = CFG_IDX_WIDTH'(2);
	localparam cfg_idx_t REG_FB_COEF_ONE = CFG_IDX_WIDTH'(3);
	localparam cfg_idx_t REG_FB_COEF_TWO = CFG_IDX_WIDTH'(4);

	localparam coef_t COEF_ONE = coef_t'(longint'(1) <<< COEF_FRAC);
	localparam logic signed [OP_WIDTH:0] ROUND_BIAS = (OP_WIDTH + 1)'(longint'(1) <<< (COEF_FRAC - 1));

	localparam rnd_t COEF_HI = rnd_t'((longint'(1) <<< (COEF_WIDTH - 1)) - 1);
	localparam rnd_t COEF_LO = rnd_t'(-(longint'(1) <<< (COEF_WIDTH - 1)));
	localparam acc_t SAMPLE_HI = acc_t'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam acc_t SAMPLE_LO = acc_t'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));

	typedef struct packed {
		coef_t gain_a0;
		coef_t ff_ratio_one;
		coef_t ff_ratio_two;
		coef_t fb_coef_one;
		coef_t fb_coef_two;
	} coef_set_t;

	typedef struct packed {
		logic start;
		op_t  mcand;
		op_t  mplier;
	} mult_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		rnd_t prod;
	} mult_stat_t;

	function automatic coef_t sat_coef(rnd_t v);
		coef_t r;
		if (v > COEF_HI) begin
			r = {1'b0, {(COEF_WIDTH-1){1'b1}}};
		end else if (v < COEF_LO) begin
			r = {1'b1, {(COEF_WIDTH-1){1'b0}}};
		end else begin
			r = v[COEF_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic sample_t sat_sample(acc_t v);
		sample_t r;
		if (v > SAMPLE_HI) begin
			r = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
		end else if (v < SAMPLE_LO) begin
			r = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
		end else begin
			r = v[SAMPLE_WIDTH-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/bqd_coef_regs.sv */
module bqd_coef_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  bqd_pkg::cfg_idx_t   cfg_index,
	input  bqd_pkg::coef_t      cfg_data,
	output bqd_pkg::coef_set_t  coefs
);
	import bqd_pkg::*;

	coef_set_t coefs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.gain_a0 <= COEF_ONE;
			coefs_q.ff_ratio_one <= '0;
			coefs_q.ff_ratio_two <= '0;
			coefs_q.fb_coef_one <= '0;
			coefs_q.fb_coef_two <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_A0: coefs_q.gain_a0 <= cfg_data;
				REG_FF_RATIO_ONE: coefs_q.ff_ratio_one <= cfg_data;
				REG_FF_RATIO_TWO: coefs_q.ff_ratio_two <= cfg_data;
				REG_FB_COEF_ONE: coefs_q.fb_coef_one <= cfg_data;
				REG_FB_COEF_TWO: coefs_q.fb_coef_two <= cfg_data;
				default: ;
			endcase
		end
	end

	assign coefs = coefs_q;

endmodule

/* hdl/bqd_serial_mult.sv */
module bqd_serial_mult (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bqd_pkg::mult_req_t   req,
	output bqd_pkg::mult_stat_t  stat
);
	import bqd_pkg::*;

	logic                    run_q;
	logic                    done_q;
	logic [CNT_WIDTH-1:0]    cnt_q;
	op_t                     mcand_q;
	logic [OP_WIDTH-1:0]     mplier_q;
	logic signed [OP_WIDTH:0] hi_q;
	logic [OP_WIDTH-1:0]     lo_q;
	logic signed [OP_WIDTH:0] addend;
	logic signed [OP_WIDTH:0] sum;
	logic                    last;

	assign last = (cnt_q == CNT_WIDTH'(OP_WIDTH - 1));

	// multiplier sign bit carries negative weight
	always_comb begin
		addend = '0;
		if (mplier_q[0]) begin
			if (last) begin
				addend = -{mcand_q[OP_WIDTH-1], mcand_q};
			end else begin
				addend = {mcand_q[OP_WIDTH-1], mcand_q};
			end
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			run_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + CNT_WIDTH'(1);
			if (last) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// rounding bias preloaded into the upper half
	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= ROUND_BIAS;
			mcand_q <= req.mcand;
			mplier_q <= req.mplier;
		end else if (run_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[OP_WIDTH-1:1]};
			mplier_q <= {1'b0, mplier_q[OP_WIDTH-1:1]};
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign stat.prod = {hi_q, lo_q[OP_WIDTH-1:COEF_FRAC]};

endmodule

/* hdl/biquad_iir_filter.sv */
// Second-order IIR filter, direct form I, signed Q1.15 samples, signed Q4.14
// coefficients. One shared bit-serial multiplier, one multiplier bit per cycle,
// forms seven rounded products per sample (the two derived feedforward taps,
// then the five filter taps), one after another. in_stall stays high until the
// result is loaded into the output register; a finished result waits there
// while the next sample is accepted. Configuration must be written only while
// idle; the block itself does not enforce this.
module biquad_iir_filter (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  bqd_pkg::sample_t       in_sample,
	output logic                   out_valid,
	input  logic                   out_stall,
	output bqd_pkg::sample_t       out_sample,
	input  logic                   cfg_we,
	input  bqd_pkg::cfg_idx_t      cfg_index,
	input  bqd_pkg::coef_t         cfg_data
);
	import bqd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ISSUE,
		S_WAIT,
		S_FINISH
	} state_t;

	typedef enum logic [2:0] {
		STEP_A1,
		STEP_A2,
		STEP_X0,
		STEP_X1,
		STEP_X2,
		STEP_Y1,
		STEP_Y2
	} step_t;

	state_t     state_q;
	step_t      step_q;
	coef_set_t  coefs;
	mult_req_t  mreq;
	mult_stat_t mstat;
	sample_t    x_q;
	sample_t    prev_in_one_q;
	sample_t    prev_in_two_q;
	sample_t    prev_out_one_q;
	sample_t    prev_out_two_q;
	coef_t      a1_q;
	coef_t      a2_q;
	acc_t       acc_q;
	logic       out_valid_q;
	sample_t    out_sample_q;
	sample_t    y;

	bqd_coef_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coefs     (coefs)
	);

	bqd_serial_mult u_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.stat   (mstat)
	);

	always_comb begin
		mreq.start = (state_q == S_ISSUE);
		unique case (step_q)
			STEP_A1: begin
				mreq.mcand = op_t'(coefs.ff_ratio_one);
				mreq.mplier = op_t'(coefs.gain_a0);
			end
			STEP_A2: begin
				mreq.mcand = op_t'(coefs.ff_ratio_two);
				mreq.mplier = op_t'(coefs.gain_a0);
			end
			STEP_X0: begin
				mreq.mcand = op_t'(x_q);
				mreq.mplier = op_t'(coefs.gain_a0);
			end
			STEP_X1: begin
				mreq.mcand = op_t'(prev_in_one_q);
				mreq.mplier = op_t'(a1_q);
			end
			STEP_X2: begin
				mreq.mcand = op_t'(prev_in_two_q);
				mreq.mplier = op_t'(a2_q);
			end
			STEP_Y1: begin
				mreq.mcand = op_t'(prev_out_one_q);
				mreq.mplier = op_t'(coefs.fb_coef_one);
			end
			STEP_Y2: begin
				mreq.mcand = op_t'(prev_out_two_q);
				mreq.mplier = op_t'(coefs.fb_coef_two);
			end
			default: begin
				mreq.mcand = '0;
				mreq.mplier = '0;
			end
		endcase
	end

	assign y = sat_sample(acc_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= STEP_A1;
			x_q <= '0;
			prev_in_one_q <= '0;
			prev_in_two_q <= '0;
			prev_out_one_q <= '0;
			prev_out_two_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
			out_sample_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q <= in_sample;
						acc_q <= '0;
						step_q <= STEP_A1;
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (mstat.done) begin
						unique case (step_q)
							STEP_A1: a1_q <= sat_coef(mstat.prod);
							STEP_A2: a2_q <= sat_coef(mstat.prod);
							STEP_X0, STEP_X1, STEP_X2: acc_q <= acc_q + acc_t'(mstat.prod);
							STEP_Y1, STEP_Y2: acc_q <= acc_q - acc_t'(mstat.prod);
							default: ;
						endcase
						if (step_q == STEP_Y2) begin
							state_q <= S_FINISH;
						end else begin
							step_q <= step_t'(step_q + 3'd1);
							state_q <= S_ISSUE;
						end
					end
				end
				S_FINISH: begin
					if (!(out_valid_q && out_stall)) begin
						out_valid_q <= 1'b1;
						out_sample_q <= y;
						prev_in_two_q <= prev_in_one_q;
						prev_in_one_q <= x_q;
						prev_out_two_q <= prev_out_one_q;
						prev_out_one_q <= y;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mstat.done |-> state_q == S_WAIT)
		else $error("multiplier done outside wait state");

	a_start_idle_mult: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |-> !mstat.busy)
		else $error("multiplier started while busy");

	a_accept_issues: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_ISSUE && step_q == STEP_A1))
		else $error("accepted beat did not start the product sequence");

	a_finish_commits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && !(out_valid_q && out_stall))
		|=> (out_valid_q && state_q == S_IDLE && out_sample_q == prev_out_one_q))
		else $error("result beat not committed with history");
`endif

endmodule

/* sim/tb_biquad_iir_filter.sv */
`timescale 1ns / 100ps

module tb_biquad_iir_filter;
	import bqd_pkg::*;

	localparam int LATENCY = 7 * (COEF_WIDTH + 2) + 2;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 800;
	localparam int PHASES = 20;
	localparam int PHASE_BEATS = 55;

	localparam sample_t SMP_TOP = sample_t'((longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1);
	localparam sample_t SMP_BOT = sample_t'(-(longint'(1) <<< (SAMPLE_WIDTH - 1)));
	localparam coef_t CF_TOP = coef_t'((longint'(1) <<< (COEF_WIDTH - 1)) - 1);
	localparam coef_t CF_BOT = coef_t'(-(longint'(1) <<< (COEF_WIDTH - 1)));
	localparam coef_t CF_HALF = coef_t'(longint'(1) <<< (COEF_FRAC - 1));

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sample_t in_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sample_t out_sample;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_GAIN_A0;
	coef_t cfg_data = '0;

	biquad_iir_filter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_sample(in_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_sample(out_sample),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// filter coefficients and history as the block should hold them
	coef_t k_gain = COEF_ONE;
	coef_t k_ff1 = '0;
	coef_t k_ff2 = '0;
	coef_t k_fb1 = '0;
	coef_t k_fb2 = '0;
	sample_t x1 = '0;
	sample_t x2 = '0;
	sample_t y1 = '0;
	sample_t y2 = '0;

	sample_t pending_q[$];
	sample_t filtered_q[$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_kick = 0;
	int errors = 0;
	int idle_cycles = 0;
	bit in_sent = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint round_mul(longint a, longint b);
		return (a * b + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint top;
		top = (longint'(1) <<< (w - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic sample_t filter_sample(sample_t x);
		longint tap1, tap2, acc;
		sample_t y;
		tap1 = clamp(round_mul(k_ff1, k_gain), COEF_WIDTH);
		tap2 = clamp(round_mul(k_ff2, k_gain), COEF_WIDTH);
		acc = round_mul(x, k_gain) + round_mul(x1, tap1) + round_mul(x2, tap2)
			- round_mul(y1, k_fb1) - round_mul(y2, k_fb2);
		y = sample_t'(clamp(acc, SAMPLE_WIDTH));
		x2 = x1;
		x1 = x;
		y2 = y1;
		y1 = y;
		return y;
	endfunction

	function automatic sample_t pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return sample_t'($urandom);
		if (r < 85)
			return sample_t'(int'($urandom_range(1024)) - 512);
		case ($urandom_range(4))
			0: return SMP_TOP;
			1: return SMP_BOT;
			2: return sample_t'(1);
			3: return sample_t'(-1);
			default: return '0;
		endcase
	endfunction

	function automatic coef_t pick_coef(int style);
		case (style)
			0: return coef_t'($urandom);
			1: begin
				case ($urandom_range(5))
					0: return CF_TOP;
					1: return CF_BOT;
					2: return COEF_ONE;
					3: return -COEF_ONE;
					4: return coef_t'(-1);
					default: return '0;
				endcase
			end
			default: return coef_t'(int'($urandom_range(32768)) - 16384);
		endcase
	endfunction

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(cfg_idx_t idx, coef_t val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_GAIN_A0: k_gain = val;
			REG_FF_RATIO_ONE: k_ff1 = val;
			REG_FF_RATIO_TWO: k_ff2 = val;
			REG_FB_COEF_ONE: k_fb1 = val;
			REG_FB_COEF_TWO: k_fb2 = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_coefs(coef_t g, coef_t f1, coef_t f2, coef_t b1, coef_t b2,
			bit poke_unused);
		write_reg(REG_GAIN_A0, g);
		write_reg(REG_FF_RATIO_ONE, f1);
		write_reg(REG_FF_RATIO_TWO, f2);
		write_reg(REG_FB_COEF_ONE, b1);
		write_reg(REG_FB_COEF_TWO, b2);
		// indexes past the register list must be dropped
		if (poke_unused) begin
			for (int k = int'(REG_FB_COEF_TWO) + 1; k < (1 << CFG_IDX_WIDTH); k++)
				write_reg(cfg_idx_t'(k), coef_t'($urandom));
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_valid || filtered_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 70;
				stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				stall_pct = 70;
			end
			default: begin
				send_idle_pct = 10;
				stall_pct = 10;
			end
		endcase
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_sent)) begin
			if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_sample <= pending_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output back-pressure, with an occasional long hold
	int hold_seen = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_kick != hold_seen) begin
			hold_seen = hold_kick;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		bit out_fire;
		sample_t want;
		in_sent = in_valid && !in_stall;
		out_fire = (out_valid === 1'b1) && !out_stall;
		if (arst_n) begin
			if (out_fire) begin
				if (filtered_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual %0d",
						$time, out_sample);
				end else begin
					want = filtered_q.pop_front();
					if (out_sample !== want) begin
						errors++;
						$display("%0t: out_sample mismatch, expected %0d, actual %0d",
							$time, want, out_sample);
					end
				end
			end
			if (in_sent)
				filtered_q.push_back(filter_sample(in_sample));
			if (in_sent || out_fire) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no beat for %0d cycles", $time, idle_cycles);
					$display("*** FAILED ***");
					$finish;
				end
			end
		end
	end

	initial begin
		coef_t g, f1, f2, b1, b2;
		int style;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity gain out of reset, sample extremes
		pending_q.push_back(SMP_TOP);
		pending_q.push_back(SMP_BOT);
		pending_q.push_back('0);
		pending_q.push_back(sample_t'(1));
		pending_q.push_back(sample_t'(-1));
		drain();

		// half gain: rounding ties go toward plus infinity
		load_coefs(CF_HALF, '0, '0, '0, '0, 1'b0);
		pending_q.push_back(sample_t'(1));
		pending_q.push_back(sample_t'(-1));
		pending_q.push_back(sample_t'(3));
		pending_q.push_back(sample_t'(-3));
		drain();

		// derived taps and output both saturate
		load_coefs(CF_TOP, CF_TOP, CF_BOT, CF_BOT, CF_TOP, 1'b1);
		pending_q.push_back(SMP_TOP);
		pending_q.push_back(SMP_BOT);
		pending_q.push_back(SMP_TOP);
		pending_q.push_back(sample_t'(1));
		pending_q.push_back(sample_t'(-1));
		pending_q.push_back('0);
		drain();

		load_coefs(CF_BOT, CF_BOT, CF_TOP, CF_TOP, CF_BOT, 1'b0);
		pending_q.push_back(SMP_BOT);
		pending_q.push_back(SMP_TOP);
		pending_q.push_back(SMP_BOT);
		pending_q.push_back('0);
		pending_q.push_back('0);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			style = (ph % 5 == 0) ? 1 : -1;
			g = pick_coef(style < 0 ? $urandom_range(2) : style);
			f1 = pick_coef(style < 0 ? $urandom_range(2) : style);
			f2 = pick_coef(style < 0 ? $urandom_range(2) : style);
			b1 = pick_coef(style < 0 ? $urandom_range(2) : style);
			b2 = pick_coef(style < 0 ? $urandom_range(2) : style);
			load_coefs(g, f1, f2, b1, b2, ph % 3 == 0);
			set_idling(idle_mode_t'(ph % 4));
			// long receiver hold while the sender keeps offering
			if (ph == 6) begin
				set_idling(IDLE_NONE);
				hold_kick++;
			end
			for (int n = 0; n < PHASE_BEATS; n++)
				pending_q.push_back(pick_sample());
			drain();
		end

		set_idling(IDLE_NONE);
		repeat (2 * LATENCY) @(posedge clk);
		if (filtered_q.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived, expected %0d, actual none",
				$time, filtered_q.size(), filtered_q[0]);
		end
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
hdl/bqd_pkg.sv
hdl/bqd_coef_regs.sv
hdl/bqd_serial_mult.sv
hdl/biquad_iir_filter.sv
sim/tb_biquad_iir_filter.sv
